[sv/i2a_pkg.sv]
// Shared types, constants and helper functions of the integer to ASCII converter.
package i2a_pkg;

    // Defaults for the top-level parameters.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths of the stream payloads.
    localparam int ROOM_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int COUNT_W     = 4;
    localparam int OUT_PAD_W   = 4;
    localparam int OUT_TDATA_W = CHAR_W + COUNT_W + OUT_PAD_W;

    // Longest text that is ever written for one item.
    localparam int MAX_CHARS = 11;

    // Conversion modes as carried in tuser.
    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // Character codes.
    localparam logic [CHAR_W-1:0] ASCII_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 8'h2D;

    localparam logic [3:0] DEC_RADIX = 4'd10;

    // Classified job handed from the front end to the back end.
    typedef struct packed {
        logic              mode;
        logic              neg;
        logic              room_zero;
        logic [ROOM_W-1:0] room;
    } t_job_ctrl;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } t_back_state;

    // Turns one digit (decimal or hex) into its ASCII code.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] digit,
                                                         input logic       upper);
        logic [CHAR_W-1:0] base;
        base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (digit < DEC_RADIX) begin
            return ASCII_ZERO + {4'd0, digit};
        end
        return base + {4'd0, digit - DEC_RADIX};
    endfunction

endpackage

[sv/i2a_queue.sv]
// Small register queue between the front end and the back end.
module i2a_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and fill-level updates, wrapping at the depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[sv/i2a_front.sv]
// Front end: accepts input items, classifies them and takes the decimal magnitude.
module i2a_front #(
    parameter int VALUE_WIDTH = 32,
    parameter int IN_TDATA_W  = 40
) (
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                      i_s_tuser,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output i2a_pkg::t_job_ctrl        o_job_ctrl,
    output logic [VALUE_WIDTH-1:0]    o_job_mag
);

    import i2a_pkg::*;

    logic [VALUE_WIDTH-1:0] value;
    logic [ROOM_W-1:0]      room;
    logic                   neg;

    // Unpack the item: value in the low bits, room above it.
    assign value = i_s_tdata[VALUE_WIDTH-1:0];
    assign room  = i_s_tdata[VALUE_WIDTH+ROOM_W-1:VALUE_WIDTH];

    // A negative decimal is written as a minus and its magnitude; the most
    // negative value negates onto itself, which read unsigned is correct.
    assign neg       = (i_s_tuser == MODE_DEC) && value[VALUE_WIDTH-1];
    assign o_job_mag = neg ? (~value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value;

    always_comb begin
        o_job_ctrl.mode      = i_s_tuser;
        o_job_ctrl.neg       = neg;
        o_job_ctrl.room_zero = (room == '0);
        o_job_ctrl.room      = room;
    end

    // An item is taken whenever the queue has space.
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;

endmodule

[sv/i2a_back.sv]
// Back end: converts a job to digits and emits one character per cycle unless stalled.
module i2a_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_hex_upper,
    input  logic                        i_q_empty,
    output logic                        o_q_pop,
    input  i2a_pkg::t_job_ctrl          i_job_ctrl,
    input  logic [VALUE_WIDTH-1:0]      i_job_mag,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]  o_m_char,
    output logic                        o_m_char_valid,
    output logic                        o_m_last,
    output logic [i2a_pkg::COUNT_W-1:0] o_m_count
);

    import i2a_pkg::*;

    // Value padded to whole nibbles; four bits are converted per cycle.
    localparam int PW    = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int NNIB  = PW / 4;
    // Decimal digits needed for VALUE_WIDTH bits (1233/4096 is just below log10(2)).
    localparam int NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W = 4 * NDIG;
    localparam int DIGW  = $clog2(NDIG);
    localparam int LENW  = $clog2(NDIG + 2);
    localparam int CNTW  = $clog2(NNIB + 1);

    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

    t_back_state r_state, n_state;

    logic [PW-1:0]      r_bin,   n_bin;
    logic [BCD_W-1:0]   r_bcd,   n_bcd;
    logic [CNTW-1:0]    r_cnt,   n_cnt;
    logic               r_neg,   n_neg;
    logic               r_zero,  n_zero;
    logic [ROOM_W-1:0]  r_room,  n_room;
    logic [DIGW-1:0]    r_pos,   n_pos;
    logic               r_minus, n_minus;
    logic [COUNT_W-1:0] r_left,  n_left;
    logic [COUNT_W-1:0] r_n,     n_n;

    logic               r_m_valid, n_m_valid;
    logic [CHAR_W-1:0]  r_m_char,  n_m_char;
    logic               r_m_cv,    n_m_cv;
    logic               r_m_last,  n_m_last;
    logic [COUNT_W-1:0] r_m_count, n_m_count;

    logic [PW-1:0]      pad_mag;
    logic [BCD_W-1:0]   hex_bcd;
    logic [BCD_W-1:0]   conv_bcd;
    logic [PW-1:0]      conv_bin;
    logic [LENW-1:0]    num_dig;
    logic [LENW-1:0]    text_len;
    logic [ROOM_W-1:0]  clip_len;
    logic [COUNT_W-1:0] size_n;
    logic [3:0]         cur_digit;
    logic [CHAR_W-1:0]  emit_char;
    logic               emit_last;
    logic               out_free;

    assign pad_mag  = PW'(i_job_mag);
    assign out_free = !r_m_valid || i_m_tready;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;

    // Hex digits are the nibbles of the value as they stand.
    always_comb begin
        hex_bcd = '0;
        for (int i = 0; i < NNIB; i++) begin
            hex_bcd[4*i +: 4] = pad_mag[4*i +: 4];
        end
    end

    // Four double-dabble steps: adjust every digit, then shift one bit in.
    always_comb begin
        logic [BCD_W-1:0] bcd_t;
        logic [PW-1:0]    bin_t;
        bcd_t = r_bcd;
        bin_t = r_bin;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (bcd_t[4*d +: 4] >= BCD_ADJ_LIMIT) begin
                    bcd_t[4*d +: 4] = bcd_t[4*d +: 4] + BCD_ADJ_ADD;
                end
            end
            bcd_t = {bcd_t[BCD_W-2:0], bin_t[PW-1]};
            bin_t = {bin_t[PW-2:0], 1'b0};
        end
        conv_bcd = bcd_t;
        conv_bin = bin_t;
    end

    // Number of significant digits, at least one, and the clipped text length.
    always_comb begin
        num_dig = LENW'(1);
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                num_dig = LENW'(i + 1);
            end
        end
        text_len = num_dig + LENW'(r_neg);
        clip_len = ROOM_W'(text_len);
        if (r_room < clip_len) begin
            clip_len = r_room;
        end
        if (clip_len > ROOM_W'(MAX_CHARS)) begin
            clip_len = ROOM_W'(MAX_CHARS);
        end
        size_n = COUNT_W'(clip_len);
    end

    // Character at the current emit position.
    assign cur_digit = r_bcd[4*r_pos +: 4];
    assign emit_last = r_zero || (r_left == COUNT_W'(1));

    always_comb begin
        if (r_zero) begin
            emit_char = ASCII_NUL;
        end else if (r_minus) begin
            emit_char = ASCII_MINUS;
        end else begin
            emit_char = digit_to_ascii(cur_digit, i_hex_upper);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job_ctrl.room_zero) begin
                        n_state = ST_EMIT;
                    end else if (i_job_ctrl.mode == MODE_HEX) begin
                        n_state = ST_SIZE;
                    end else begin
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                if (r_cnt == CNTW'(1)) begin
                    n_state = ST_SIZE;
                end
            end
            ST_SIZE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates per state.
    always_comb begin
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_neg     = r_neg;
        n_zero    = r_zero;
        n_room    = r_room;
        n_pos     = r_pos;
        n_minus   = r_minus;
        n_left    = r_left;
        n_n       = r_n;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_char  = r_m_char;
        n_m_cv    = r_m_cv;
        n_m_last  = r_m_last;
        n_m_count = r_m_count;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    n_bin   = pad_mag;
                    n_bcd   = (i_job_ctrl.mode == MODE_HEX) ? hex_bcd : '0;
                    n_cnt   = CNTW'(NNIB);
                    n_neg   = i_job_ctrl.neg;
                    n_zero  = i_job_ctrl.room_zero;
                    n_room  = i_job_ctrl.room;
                    n_minus = i_job_ctrl.neg;
                    n_left  = COUNT_W'(1);
                    n_n     = '0;
                end
            end
            ST_CONV: begin
                n_bin = conv_bin;
                n_bcd = conv_bcd;
                n_cnt = r_cnt - 1'b1;
            end
            ST_SIZE: begin
                n_pos  = DIGW'(num_dig - 1'b1);
                n_left = size_n;
                n_n    = size_n;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = emit_char;
                    n_m_cv    = !r_zero;
                    n_m_last  = emit_last;
                    n_m_count = emit_last ? r_n : '0;
                    if (r_minus) begin
                        n_minus = 1'b0;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                    n_left = r_left - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // Working and payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_neg     <= n_neg;
        r_zero    <= n_zero;
        r_room    <= n_room;
        r_pos     <= n_pos;
        r_minus   <= n_minus;
        r_left    <= n_left;
        r_n       <= n_n;
        r_m_char  <= n_m_char;
        r_m_cv    <= n_m_cv;
        r_m_last  <= n_m_last;
        r_m_count <= n_m_count;
    end

    assign o_m_tvalid     = r_m_valid;
    assign o_m_char       = r_m_char;
    assign o_m_char_valid = r_m_cv;
    assign o_m_last       = r_m_last;
    assign o_m_count      = r_m_count;

endmodule

[sv/integer_to_ascii_converter.sv]
// Top level of the integer to ASCII converter.
//
// Usage: each item on the s_axis channel carries a value, a room limit and a
// mode in tuser (0 signed decimal, 1 unsigned hex). The block answers with
// one m_axis item per character, most significant digit first, with a minus
// in front of a negative decimal. tuser on the output is 1 for a real
// character; tlast marks the final item, which also carries the character
// count. A room of zero gives one item with tuser 0, tlast 1 and count 0.
// The cfg channel sets the hex letter case; it is always ready.
// A decimal item is converted in the double-dabble unit, four bits per
// cycle, then sized, and its characters follow; hex items skip the
// conversion steps. The back end handles one item at a time; a queue of
// QUEUE_DEPTH entries lets further input items be taken meanwhile.
// Reset empties the queue and the output register and clears the letter
// case to lower. When the receiver holds tready low, the output item waits
// in its register and the back end holds at its next character; the queue
// keeps taking input until it is full.
module integer_to_ascii_converter #(
    parameter int VALUE_WIDTH = i2a_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Input stream. tdata: value [VALUE_WIDTH-1:0], room above it, zero fill.
    // tuser: mode.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [((VALUE_WIDTH + i2a_pkg::ROOM_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic s_axis_tuser,
    // Output stream. tdata: character [7:0], written_count [11:8], zero fill.
    // tuser: char_valid.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [i2a_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic m_axis_tuser,
    output logic m_axis_tlast,
    // Configuration: hex letter case.
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    import i2a_pkg::*;

    localparam int IN_TDATA_W = ((VALUE_WIDTH + ROOM_W + 7) / 8) * 8;
    localparam int JOB_W      = $bits(t_job_ctrl) + VALUE_WIDTH;

    logic                   r_hex_upper;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_push;
    logic                   q_pop;
    t_job_ctrl              front_ctrl;
    logic [VALUE_WIDTH-1:0] front_mag;
    logic [JOB_W-1:0]       q_out;
    t_job_ctrl              back_ctrl;
    logic [VALUE_WIDTH-1:0] back_mag;
    logic [CHAR_W-1:0]      out_char;
    logic [COUNT_W-1:0]     out_count;

    // Letter case register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex_upper <= 1'b0;
        end else if (i_cfg_valid) begin
            r_hex_upper <= i_cfg_data;
        end
    end

    i2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .IN_TDATA_W  (IN_TDATA_W)
    ) u_front (
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_job_ctrl (front_ctrl),
        .o_job_mag  (front_mag)
    );

    i2a_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_ctrl, front_mag}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign back_ctrl = q_out[JOB_W-1:VALUE_WIDTH];
    assign back_mag  = q_out[VALUE_WIDTH-1:0];

    i2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hex_upper    (r_hex_upper),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_job_ctrl     (back_ctrl),
        .i_job_mag      (back_mag),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_char       (out_char),
        .o_m_char_valid (m_axis_tuser),
        .o_m_last       (m_axis_tlast),
        .o_m_count      (out_count)
    );

    // Pack the result item.
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_count, out_char};

endmodule

[sv/i2a_checker.sv]
// Port-level checks of the integer to ASCII converter and their binding.
module i2a_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [i2a_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);

    import i2a_pkg::*;

    logic [COUNT_W-1:0] count;

    assign count = m_axis_tdata[CHAR_W+COUNT_W-1:CHAR_W];

    // A waiting output item is not withdrawn.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item withdrawn while stalled");

    // An item without a character is the lone answer to room zero.
    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && count == '0)
        else $error("empty item is not a final item with count zero");

    // Only the final item carries a count.
    a_count_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> count == '0)
        else $error("count set on a non-final item");

    // A final character item reports between one and the most characters.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser
            |-> count != '0 && count <= COUNT_W'(MAX_CHARS))
        else $error("final count out of range");

endmodule

bind integer_to_ascii_converter i2a_checker u_i2a_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
